// ----- hdl/lpld_pkg.sv -----
// ----------------------------------------------------------------------------
// lpld_pkg
// Types and constants shared by the length-prefixed list deframer.
// ----------------------------------------------------------------------------
package lpld_pkg;

  localparam int unsigned LPLD_BYTE_W  = 8;
  localparam int unsigned LPLD_LEN_W   = 2 * LPLD_BYTE_W;
  localparam int unsigned LPLD_QDEPTH  = 4;   // result queue entries, at least 2

  typedef enum logic [2:0] {
    PH_OUTER_HI = 3'd0,
    PH_OUTER_LO = 3'd1,
    PH_ITEM_HI  = 3'd2,
    PH_ITEM_LO  = 3'd3,
    PH_PAYLOAD  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_HEADER  = 2'd1,
    K_OK      = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [LPLD_BYTE_W-1:0] data_byte;
    logic                   end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    kind_t                 kind;
    logic [LPLD_LEN_W-1:0] value;
    logic                  item_end;
    logic                  run_last;
  } out_beat_t;

endpackage

// ----- hdl/length_prefixed_list_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_list_deframer
// Parses lists of 16-bit length-prefixed items from a byte stream and emits
// item headers, payload bytes and a per-list ok/error status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+-------------------------------
//  up      | in        | up_valid/up_stall  | in_beat_t  : data_byte, end_of_buffer
//  dn      | out       | dn_valid/dn_stall  | out_beat_t : kind, value, item_end, run_last
//
//  One input byte is taken per cycle while up_stall is low. Its results (up to
//  two) are worked out in the same cycle and written into a QDEPTH-entry result
//  queue, whose head drives dn directly.
//  A byte that closes an item and also carries end_of_buffer yields two
//  results, which drain at one per cycle through the queue while dn_stall is low.
//  up_stall rises when the queue lacks room for two more results.
//  rst (synchronous) returns the parser to the outer length high byte and
//  empties the queue.
// ----------------------------------------------------------------------------
module length_prefixed_list_deframer
  import lpld_pkg::*;
#(
  parameter int unsigned QDEPTH = LPLD_QDEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_stall,
  input  in_beat_t  up_beat,
  output logic      dn_valid,
  input  logic      dn_stall,
  output out_beat_t dn_beat
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  // Parser state
  phase_t                 phase, phase_next;
  logic [LPLD_LEN_W-1:0]  list_left, list_left_next;
  logic [LPLD_LEN_W-1:0]  item_left, item_left_next;
  logic                   failed, failed_next;
  logic [LPLD_BYTE_W-1:0] saved_high, saved_high_next;

  // Result queue
  out_beat_t          queue [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr, wr_ptr_inc;
  logic [CNT_W-1:0]   count;

  logic up_take, dn_take;

  // Shared decode of the current byte
  logic [LPLD_LEN_W-1:0] left_dec, item_dec, item_len;
  logic                  in_body, body_ok, last;

  // Results of this byte
  logic      bad;
  logic      main_emit;
  out_beat_t main_res;
  out_beat_t stat_res;
  logic [1:0] res_n;

  assign up_take = up_valid && !up_stall;
  assign dn_take = dn_valid && !dn_stall;

  assign last     = up_beat.end_of_buffer;
  assign left_dec = list_left - LPLD_LEN_W'(1);
  assign item_dec = item_left - LPLD_LEN_W'(1);
  assign item_len = {saved_high, up_beat.data_byte};
  assign in_body  = (phase == PH_ITEM_HI) || (phase == PH_ITEM_LO) ||
                    (phase == PH_PAYLOAD);
  assign body_ok  = !failed && in_body && (list_left != '0);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next      = phase;
    list_left_next  = list_left;
    item_left_next  = item_left;
    failed_next     = failed;
    saved_high_next = saved_high;
    bad             = 1'b0;

    if (!failed) begin
      case (phase)
        PH_OUTER_HI: begin
          saved_high_next = up_beat.data_byte;
          phase_next      = PH_OUTER_LO;
          bad             = last;
        end
        PH_OUTER_LO: begin
          list_left_next = item_len;
          phase_next     = PH_ITEM_HI;
          bad            = last;
        end
        PH_ITEM_HI: begin
          if (list_left == '0) begin
            failed_next = 1'b1;
          end else begin
            list_left_next = left_dec;
            // need room for the low byte of the prefix
            if (left_dec == '0) begin
              failed_next = 1'b1;
            end else begin
              saved_high_next = up_beat.data_byte;
              phase_next      = PH_ITEM_LO;
            end
          end
        end
        PH_ITEM_LO: begin
          if (list_left == '0) begin
            failed_next = 1'b1;
          end else begin
            list_left_next = left_dec;
            // reject an item longer than the rest of the list
            if (item_len > left_dec) begin
              failed_next = 1'b1;
            end else begin
              item_left_next = item_len;
              phase_next     = (item_len == '0) ? PH_ITEM_HI : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (list_left == '0) begin
            failed_next = 1'b1;
          end else begin
            list_left_next = left_dec;
            item_left_next = item_dec;
            if (item_dec == '0) begin
              phase_next = PH_ITEM_HI;
            end
          end
        end
        default: begin
          phase_next = PH_OUTER_HI;
        end
      endcase
    end

    // Close the list: judge it on the updated state, then return the parser
    // to its reset state
    if (last) begin
      bad             = bad || failed_next || (list_left_next != '0);
      phase_next      = PH_OUTER_HI;
      list_left_next  = '0;
      item_left_next  = '0;
      failed_next     = 1'b0;
      saved_high_next = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Results
  // --------------------------------------------------------------------------
  always_comb begin
    main_emit         = 1'b0;
    main_res.kind     = K_PAYLOAD;
    main_res.value    = '0;
    main_res.item_end = 1'b0;
    main_res.run_last = 1'b0;

    case (phase)
      PH_ITEM_LO: begin
        if (body_ok && !(item_len > left_dec)) begin
          main_emit         = 1'b1;
          main_res.kind     = K_HEADER;
          main_res.value    = item_len;
          main_res.item_end = (item_len == '0);
        end
      end
      PH_PAYLOAD: begin
        if (body_ok) begin
          main_emit         = 1'b1;
          main_res.kind     = K_PAYLOAD;
          main_res.value    = {{(LPLD_LEN_W-LPLD_BYTE_W){1'b0}}, up_beat.data_byte};
          main_res.item_end = (item_dec == '0);
        end
      end
      default: begin
        main_emit = 1'b0;
      end
    endcase
    main_res.run_last = !last;

    stat_res.kind     = bad ? K_ERROR : K_OK;
    stat_res.value    = '0;
    stat_res.item_end = 1'b0;
    stat_res.run_last = 1'b1;

    res_n = {1'b0, main_emit} + {1'b0, last};
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OUTER_HI;
      list_left  <= '0;
      item_left  <= '0;
      failed     <= 1'b0;
      saved_high <= '0;
    end else if (up_take) begin
      phase      <= phase_next;
      list_left  <= list_left_next;
      item_left  <= item_left_next;
      failed     <= failed_next;
      saved_high <= saved_high_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two pushes and one pop per cycle
  // --------------------------------------------------------------------------
  assign wr_ptr_inc = (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (up_take) begin
      if (main_emit) begin
        queue[wr_ptr] <= main_res;
        if (last) begin
          queue[wr_ptr_inc] <= stat_res;
        end
      end else if (last) begin
        queue[wr_ptr] <= stat_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (up_take) begin
        case (res_n)
          2'd1:    wr_ptr <= wr_ptr_inc;
          2'd2:    wr_ptr <= (wr_ptr_inc == PTR_W'(QDEPTH - 1)) ? '0
                             : wr_ptr_inc + PTR_W'(1);
          default: wr_ptr <= wr_ptr;
        endcase
      end
      if (dn_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + (up_take ? CNT_W'(res_n) : '0) - CNT_W'(dn_take);
    end
  end

  // Hold off the source until two free entries remain
  assign up_stall = (count > CNT_W'(QDEPTH - 2));
  assign dn_valid = (count != '0);
  assign dn_beat  = queue[rd_ptr];

endmodule
